[rtl/core/smi_pkg.sv]
// shared types, operation and error codes for the sign-magnitude 128-bit alu
// no dependencies
package smi_pkg;

	localparam int WordW = 128;
	localparam int HalfW = 64;
	localparam int Steps = 128;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_DIV  = 4'd2,
		OP_MOD  = 4'd3,
		OP_MUL  = 4'd4,
		OP_EQ   = 4'd5,
		OP_NE   = 4'd6,
		OP_GT   = 4'd7,
		OP_LE   = 4'd8,
		OP_FROM = 4'd9
	} op_e;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DIV0 = 2'd2
	} err_e;

	typedef struct packed {
		logic [3:0]       operation;
		logic [HalfW-1:0] lhs_high;
		logic [HalfW-1:0] lhs_low;
		logic [HalfW-1:0] rhs_high;
		logic [HalfW-1:0] rhs_low;
	} in_t;

	typedef struct packed {
		logic [HalfW-1:0] result_high;
		logic [HalfW-1:0] result_low;
		logic             truth;
		logic [1:0]       error;
	} out_t;

	// state carried down the cell chain
	typedef struct packed {
		logic [3:0]       op;
		logic             use_cell;
		logic             neg;
		logic [WordW-1:0] src;
		logic [WordW-1:0] dvs;
		logic [WordW-1:0] acc;
		logic [WordW-1:0] quo;
		logic             ovf;
		out_t             res;
	} stage_t;

	// sign and 128-bit magnitude to encoding; zero magnitude is positive
	function automatic out_t encode(input logic neg, input logic [WordW-1:0] mag);
		out_t r;
		r = '0;
		if (mag[WordW-1]) begin
			r.error = ERR_OVF;
		end else begin
			r.result_high = {neg && (mag != '0), mag[WordW-2:HalfW]};
			r.result_low  = mag[HalfW-1:0];
			r.error       = ERR_NONE;
		end
		return r;
	endfunction

endpackage

[rtl/core/sign_magnitude_int127_alu.sv]
// Sign-magnitude 128-bit integer alu: add, subtract, divide, remainder, multiply by a
// signed 64-bit value, compares and conversion. Every item passes an input register, a
// chain of 128 step cells and an output register, and a new item is taken every cycle
// unless the output stalls; the division and multiplication run one bit per cell down
// the chain. While the output holds an untaken result the whole chain stalls.
// depends on smi_pkg, smi_front, smi_cell, smi_back
module sign_magnitude_int127_alu (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  smi_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output smi_pkg::out_t  out_data
);
	import smi_pkg::*;

	logic   adv;
	stage_t front_st;
	stage_t chain [0:Steps];
	logic   chain_v [0:Steps];
	out_t   back_res;
	logic   valid_s1;
	stage_t stage_s1;
	logic   out_valid_q;
	out_t   out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	smi_front u_front (.din(in_data), .st(front_st));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			stage_s1 <= front_st;
	end

	assign chain[0]   = stage_s1;
	assign chain_v[0] = valid_s1;

	for (genvar i = 0; i < Steps; i++) begin : g_cell
		smi_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (chain_v[i]),
			.in_stage (chain[i]),
			.out_valid(chain_v[i+1]),
			.out_stage(chain[i+1])
		);
	end

	smi_back u_back (.st(chain[Steps]), .res(back_res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= chain_v[Steps];
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= back_res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// an error result carries a zero word
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error != ERR_NONE) |->
		(out_data.result_high == '0) && (out_data.result_low == '0))
		else $error("error result with nonzero word");

	// no item enters while the output stalls
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken during output stall");

	// a result enters the output register only from a valid chain end
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(chain_v[Steps]))
		else $error("result without a finished item");

endmodule

[rtl/core/smi_front.sv]
// decode and the operations that need no cell chain, sets up the cell chain state
// depends on smi_pkg
module smi_front (
	input  smi_pkg::in_t    din,
	output smi_pkg::stage_t st
);
	import smi_pkg::*;

	logic             sa, sb, na, nb, nsub, gt, mneg;
	logic [WordW-1:0] ma, mb, sum, dif_ab, dif_ba;
	logic [HalfW-1:0] mabs;

	always_comb begin
		sa     = din.lhs_high[HalfW-1];
		sb     = din.rhs_high[HalfW-1];
		ma     = {1'b0, din.lhs_high[HalfW-2:0], din.lhs_low};
		mb     = {1'b0, din.rhs_high[HalfW-2:0], din.rhs_low};
		nsub   = (op_e'(din.operation) == OP_SUB) ? !sb : sb;
		sum    = ma + mb;
		dif_ab = ma - mb;
		dif_ba = mb - ma;
		na     = sa && (ma != '0);
		nb     = sb && (mb != '0);
		if (na != nb)
			gt = nb;
		else if (!na)
			gt = ma > mb;
		else
			gt = mb > ma;
		mneg = din.rhs_low[HalfW-1];
		mabs = mneg ? (~din.rhs_low + 1'b1) : din.rhs_low;

		st          = '0;
		st.op       = din.operation;
		case (op_e'(din.operation))
			OP_ADD, OP_SUB: begin
				if (sa == nsub)
					st.res = encode(sa, sum);
				else if (ma >= mb)
					st.res = encode(sa, dif_ab);
				else
					st.res = encode(nsub, dif_ba);
			end
			OP_DIV, OP_MOD: begin
				if (mb == '0) begin
					st.res.error = ERR_DIV0;
				end else begin
					st.use_cell = 1'b1;
					st.neg      = (op_e'(din.operation) == OP_DIV) ? (sa != sb) : sa;
					st.src      = ma;
					st.dvs      = mb;
				end
			end
			OP_MUL: begin
				// leading zero steps leave the accumulator at zero
				st.use_cell = 1'b1;
				st.neg      = sa != mneg;
				st.src      = {{(WordW-HalfW){1'b0}}, mabs};
				st.dvs      = ma;
			end
			OP_EQ:   st.res.truth = (din.lhs_high == din.rhs_high) && (din.lhs_low == din.rhs_low);
			OP_NE:   st.res.truth = (din.lhs_high != din.rhs_high) || (din.lhs_low != din.rhs_low);
			OP_GT:   st.res.truth = gt;
			OP_LE:   st.res.truth = !gt;
			OP_FROM: st.res = encode(mneg, {{(WordW-HalfW){1'b0}}, mabs});
			default: st.res = '0;
		endcase
	end

endmodule

[rtl/core/smi_cell.sv]
// one step of restoring division or shift-add multiplication, registered
// depends on smi_pkg
module smi_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  smi_pkg::stage_t in_stage,
	output logic            out_valid,
	output smi_pkg::stage_t out_stage
);
	import smi_pkg::*;

	stage_t         nxt;
	logic           bit_in, ge;
	logic [WordW-1:0] part;
	logic [WordW:0]   msum;
	logic             valid_q;
	stage_t           stage_q;

	always_comb begin
		nxt    = in_stage;
		bit_in = in_stage.src[WordW-1];
		part   = {in_stage.acc[WordW-2:0], bit_in};
		ge     = part >= in_stage.dvs;
		msum   = {in_stage.acc, 1'b0} + (bit_in ? {1'b0, in_stage.dvs} : '0);
		if (in_stage.use_cell) begin
			nxt.src = {in_stage.src[WordW-2:0], 1'b0};
			if (op_e'(in_stage.op) == OP_MUL) begin
				// once past 2^127 the product only grows
				nxt.ovf = in_stage.ovf | msum[WordW] | msum[WordW-1];
				nxt.acc = msum[WordW-1:0];
			end else begin
				nxt.acc = ge ? (part - in_stage.dvs) : part;
				nxt.quo = {in_stage.quo[WordW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			stage_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_stage = stage_q;

endmodule

[rtl/core/smi_back.sv]
// final encoding of quotient, remainder or product after the chain
// depends on smi_pkg
module smi_back (
	input  smi_pkg::stage_t st,
	output smi_pkg::out_t   res
);
	import smi_pkg::*;

	always_comb begin
		res = st.res;
		if (st.use_cell) begin
			case (op_e'(st.op))
				OP_DIV: res = encode(st.neg, st.quo);
				OP_MOD: res = encode(st.neg, st.acc);
				OP_MUL: begin
					if (st.ovf) begin
						res       = '0;
						res.error = ERR_OVF;
					end else begin
						res = encode(st.neg, st.acc);
					end
				end
				default: res = st.res;
			endcase
		end
	end

endmodule

[bench/sign_magnitude_int127_alu_tb.sv]
// testbench for the sign-magnitude 128-bit alu: directed and random operands,
// an in-bench predictor and an ordered check of every result
// depends on smi_pkg and sign_magnitude_int127_alu
module sign_magnitude_int127_alu_tb;
	import smi_pkg::*;

	// expected results in order of acceptance, with the predictor
	class alu_results;
		out_t pending[$];
		int   mismatches;

		function automatic out_t pack_mag(input bit neg, input bit [127:0] mag);
			out_t r;
			r = '0;
			if (mag[127]) begin
				r.error = ERR_OVF;
			end else begin
				r.result_high = {neg && (mag != 0), mag[126:64]};
				r.result_low = mag[63:0];
			end
			return r;
		endfunction

		function automatic bit above(input bit sa, input bit [127:0] ma,
				input bit sb, input bit [127:0] mb);
			bit na, nb;
			na = sa && ma != 0;
			nb = sb && mb != 0;
			if (na != nb)
				return nb;
			return na ? (mb > ma) : (ma > mb);
		endfunction

		function automatic out_t predict(input in_t x);
			out_t r;
			bit sa, sb, nb, nm;
			bit [127:0] ma, mb;
			bit [63:0] m;
			bit [191:0] prod;
			r = '0;
			sa = x.lhs_high[63];
			sb = x.rhs_high[63];
			ma = {1'b0, x.lhs_high[62:0], x.lhs_low};
			mb = {1'b0, x.rhs_high[62:0], x.rhs_low};
			case (x.operation)
				OP_ADD, OP_SUB: begin
					nb = (x.operation == OP_SUB) ? !sb : sb;
					if (sa == nb)
						r = pack_mag(sa, ma + mb);
					else if (ma >= mb)
						r = pack_mag(sa, ma - mb);
					else
						r = pack_mag(nb, mb - ma);
				end
				OP_DIV, OP_MOD: begin
					if (mb == 0)
						r.error = ERR_DIV0;
					else if (x.operation == OP_DIV)
						r = pack_mag(sa != sb, ma / mb);
					else
						r = pack_mag(sa, ma % mb);
				end
				OP_MUL: begin
					m = x.rhs_low;
					nm = m[63];
					if (nm)
						m = -m;
					prod = ma * m;
					if (prod[191:127] != 0)
						r.error = ERR_OVF;
					else
						r = pack_mag(sa != nm, prod[127:0]);
				end
				OP_EQ: r.truth = {x.lhs_high, x.lhs_low} == {x.rhs_high, x.rhs_low};
				OP_NE: r.truth = {x.lhs_high, x.lhs_low} != {x.rhs_high, x.rhs_low};
				OP_GT: r.truth = above(sa, ma, sb, mb);
				OP_LE: r.truth = !above(sa, ma, sb, mb);
				OP_FROM: begin
					m = x.rhs_low;
					r = pack_mag(m[63], {64'd0, m[63] ? -m : m});
				end
				default: r = '0;
			endcase
			return r;
		endfunction

		function void note_input(input in_t x);
			pending.push_back(predict(x));
		endfunction

		function void check_result(input out_t got);
			out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want hi %h lo %h t %b e %0d, got hi %h lo %h t %b e %0d",
						want.result_high, want.result_low, want.truth, want.error,
						got.result_high, got.result_low, got.truth, got.error);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	in_t in_data;
	out_t out_data;
	alu_results sb;
	bit calm, hold_off;
	longint cycles;

	sign_magnitude_int127_alu uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand_half();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = '1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h7fff_ffff_ffff_ffff;
			4: v = v >> $urandom_range(0, 63);
			default: ;
		endcase
		return v;
	endfunction

	function automatic in_t rand_item();
		in_t x;
		x.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
			: 4'($urandom_range(0, 9));
		x.lhs_high = rand_half();
		x.lhs_low = rand_half();
		x.rhs_high = rand_half();
		x.rhs_low = rand_half();
		if ($urandom_range(0, 7) == 0) begin
			x.rhs_high = x.lhs_high ^ {1'($urandom_range(0, 1)), 63'd0};
			x.rhs_low = x.lhs_low;
		end
		if ((x.operation == OP_DIV || x.operation == OP_MOD) && $urandom_range(0, 2) == 0)
			x.rhs_high[62:0] = x.rhs_high[62:0] >> $urandom_range(1, 63);
		return x;
	endfunction

	function automatic in_t mk(input op_e op, input logic [63:0] a, b, c, d);
		in_t x;
		x.operation = op;
		x.lhs_high = a;
		x.lhs_low = b;
		x.rhs_high = c;
		x.rhs_low = d;
		return x;
	endfunction

	// hold valid until the transfer, idle in bursts unless calm
	task automatic send_item(input in_t x);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		sb.note_input(x);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// receiver: random stalls, one long hold-off
	initial begin
		int burst;
		out_ready = 0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			if (burst > 0) begin
				burst--;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 8);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("** sign_magnitude_int127_alu: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		localparam logic [63:0] SGN = 64'h8000_0000_0000_0000;
		localparam logic [63:0] MX = 64'h7fff_ffff_ffff_ffff;
		in_t directed[$];
		sb = new();
		calm = 0;
		hold_off = 0;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed = '{
			mk(OP_ADD, MX, '1, 0, 1),
			mk(OP_ADD, MX, '1, SGN, 1),
			mk(OP_SUB, SGN, 0, 0, 0),
			mk(OP_SUB, SGN | MX, '1, MX, '1),
			mk(OP_SUB, 0, 5, 0, 9),
			mk(OP_DIV, 0, 7, SGN, 0),
			mk(OP_MOD, SGN, 7, 0, 0),
			mk(OP_DIV, SGN | MX, '1, 0, 3),
			mk(OP_MOD, SGN, 7, SGN, 3),
			mk(OP_DIV, 0, 3, 0, 7),
			mk(OP_MUL, 0, '1, 0, SGN),
			mk(OP_MUL, 0, 1, 0, SGN),
			mk(OP_MUL, MX, '1, 0, '1),
			mk(OP_MUL, SGN, 0, 0, 5),
			mk(OP_EQ, SGN, 0, 0, 0),
			mk(OP_EQ, 5, 6, 5, 6),
			mk(OP_NE, SGN, 0, 0, 0),
			mk(OP_GT, SGN, 0, 0, 0),
			mk(OP_GT, 0, 1, SGN, 9),
			mk(OP_LE, SGN, 0, 0, 0),
			mk(OP_LE, SGN | MX, '1, MX, '1),
			mk(OP_FROM, 0, 0, 0, SGN),
			mk(OP_FROM, '1, '1, '1, '1),
			mk(OP_FROM, 0, 0, 0, MX),
			mk(op_e'(4'd15), '1, '1, '1, '1)
		};
		foreach (directed[i])
			send_item(directed[i]);
		for (int n = 0; n < 1850; n++) begin
			if (n == 300)
				hold_off = 1;
			if (n == 1600)
				calm = 1;
			send_item(rand_item());
		end
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** sign_magnitude_int127_alu: PASSED **");
		else
			$display("** sign_magnitude_int127_alu: FAILED **");
		$finish;
	end
endmodule

[sim.f]
rtl/core/smi_pkg.sv
rtl/core/smi_front.sv
rtl/core/smi_cell.sv
rtl/core/smi_back.sv
rtl/core/sign_magnitude_int127_alu.sv
bench/sign_magnitude_int127_alu_tb.sv
